>>> sv/dsl_pkg.sv
// Shared types and constants for the dual sorted list engine.
// Used by dsl_cell, dsl_list and dual_sorted_list_engine_core; depends on nothing.
package dsl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int KEY_BITS = 16;
	localparam int FIELD_KEY_BITS = 16;
	localparam int FIELD_CNT_BITS = 5;
	localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	// Operation codes.
	localparam logic [1:0] OP_INS_ACTIVE  = 2'd0;
	localparam logic [1:0] OP_INS_PENDING = 2'd1;
	localparam logic [1:0] OP_REMOVE      = 2'd2;
	localparam logic [1:0] OP_PROMOTE     = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Broadcast control to every cell of a list.
	typedef struct packed {
		logic ins;
		logic rem;
		logic pop;
	} cell_ctl_t;

	// Command to one list: insert key, remove first match of key, or drop the head.
	typedef struct packed {
		logic ins;
		logic rem;
		logic pop;
		key_t key;
	} list_cmd_t;

	// Status of one list as seen by the control logic.
	typedef struct packed {
		key_t head;
		logic full;
		logic empty;
		logic found;
		cnt_t fill;
	} list_stat_t;

endpackage

>>> sv/dual_sorted_list_engine_core.sv
// Top level of the dual sorted list engine: two cell-chain lists and the request decode.
// Depends on dsl_pkg, dsl_list and dsl_cell.
//
// Channel   Direction  Handshake            Fields
// request   in         start high, busy low operation, item_key
// result    out        done for one cycle   status, moved_key, active_count, pending_count
//
// Each list is a row of cells that all compare against the request key at once and
// shift by one place, so every request finishes in the cycle it is accepted.
// The result is registered and appears in the cycle after acceptance, and busy stays low, so a new request
// may be issued every cycle; throughput is one request per clock.
// Reset empties both lists by clearing their fill counts; entry contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module dual_sorted_list_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [15:0] item_key,
	output logic       done,
	output logic [1:0] status,
	output logic [15:0] moved_key,
	output logic [4:0] active_count,
	output logic [4:0] pending_count
);
	import dsl_pkg::*;

	list_cmd_t  act_cmd;
	list_cmd_t  pnd_cmd;
	list_stat_t act_stat;
	list_stat_t pnd_stat;
	key_t       key;
	logic       accept;
	logic [1:0] status_d;
	key_t       moved_d;
	logic       done_q;
	logic [1:0] status_q;
	key_t       moved_q;

	// Every request completes in the cycle it is accepted, so the engine never refuses one.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign key    = key_t'(item_key);

	// Decode the request into list commands. Insert and promote commands are only raised when
	// the operation will succeed and a removal is gated inside the list, so a refused request leaves both lists untouched.
	always_comb begin
		act_cmd     = '0;
		pnd_cmd     = '0;
		act_cmd.key = key;
		pnd_cmd.key = key;
		status_d    = ST_OK;
		moved_d     = '0;
		unique case (operation)
			OP_INS_ACTIVE: begin
				if (act_stat.full) begin
					status_d = ST_FULL;
				end else begin
					act_cmd.ins = accept;
				end
			end
			OP_INS_PENDING: begin
				if (pnd_stat.full) begin
					status_d = ST_FULL;
				end else begin
					pnd_cmd.ins = accept;
				end
			end
			OP_REMOVE: begin
				act_cmd.rem = accept;
				if (!act_stat.found) begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_PROMOTE: begin
				// The pending head moves into the active list by the normal insert rule.
				if (pnd_stat.empty) begin
					status_d = ST_EMPTY;
				end else if (act_stat.full) begin
					status_d = ST_FULL;
				end else begin
					act_cmd.key = pnd_stat.head;
					act_cmd.ins = accept;
					pnd_cmd.pop = accept;
					moved_d     = pnd_stat.head;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	dsl_list u_active (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (act_cmd),
		.stat   (act_stat)
	);

	dsl_list u_pending (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pnd_cmd),
		.stat   (pnd_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// Result payload is captured with the request; the counts are read live from the
	// fill registers, which hold the post-request values during the result cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			moved_q  <= moved_d;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign moved_key     = FIELD_KEY_BITS'(moved_q);
	assign active_count  = FIELD_CNT_BITS'(act_stat.fill);
	assign pending_count = FIELD_CNT_BITS'(pnd_stat.fill);

`ifndef SYNTHESIS
	// A pending insert reports ok exactly when the pending count grew by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_INS_PENDING) |=>
		((status == ST_OK) == (pending_count == $past(pending_count) + 5'd1)))
		else $error("pending insert status disagrees with count change");

	// An empty report on promote means the pending list really was empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (pending_count == 5'd0))
		else $error("pending empty reported with entries present");

	// A promote never creates or loses entries across the two lists.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_PROMOTE) |=>
		((6'(active_count) + 6'(pending_count)) ==
		$past(6'(active_count) + 6'(pending_count))))
		else $error("promote changed the total entry count");
`endif

endmodule

>>> sv/dsl_cell.sv
// One entry of a sorted list: holds a key and trades it with its neighbors.
// Depends on dsl_pkg.
module dsl_cell (
	input  logic              clk,
	input  dsl_pkg::cell_ctl_t ctl,
	input  dsl_pkg::key_t     key,
	input  logic              valid,
	input  logic              left_lt,
	input  dsl_pkg::key_t     left_entry,
	input  dsl_pkg::key_t     right_entry,
	input  logic              hit_in,
	output logic              lt,
	output logic              hit_out,
	output dsl_pkg::key_t     entry
);
	import dsl_pkg::*;

	key_t entry_q;

	// Empty cells count as smaller than any key, so an insert with no smaller entry lands at the fill point.
	assign lt      = !valid || (entry_q < key);
	assign hit_out = hit_in || (valid && (entry_q == key));
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && lt) begin
			entry_q <= left_lt ? left_entry : key;
		end else if ((ctl.rem && hit_out) || ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

>>> sv/dsl_list.sv
// A descending sorted list built as a row of dsl_cell instances plus a fill count.
// Depends on dsl_pkg and dsl_cell.
module dsl_list (
	input  logic               clk,
	input  logic               arst_n,
	input  dsl_pkg::list_cmd_t cmd,
	output dsl_pkg::list_stat_t stat
);
	import dsl_pkg::*;

	cnt_t      fill_q;
	logic      lt_c  [LIST_DEPTH];
	logic      hit_c [LIST_DEPTH+1];
	key_t      ent_c [LIST_DEPTH];
	cell_ctl_t ctl;
	logic      found;

	assign hit_c[0] = 1'b0;
	assign found    = hit_c[LIST_DEPTH];

	// A removal only moves cells when the key is present.
	assign ctl.ins = cmd.ins;
	assign ctl.rem = cmd.rem && found;
	assign ctl.pop = cmd.pop;

	for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
		logic lft_lt;
		key_t lft_ent;
		key_t rgt_ent;
		if (g == 0) begin : g_first
			assign lft_lt  = 1'b0;
			assign lft_ent = cmd.key;
		end else begin : g_mid
			assign lft_lt  = lt_c[g-1];
			assign lft_ent = ent_c[g-1];
		end
		if (g == LIST_DEPTH - 1) begin : g_last
			assign rgt_ent = ent_c[g];
		end else begin : g_inner
			assign rgt_ent = ent_c[g+1];
		end
		dsl_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.key         (cmd.key),
			.valid       (CNT_BITS'(g) < fill_q),
			.left_lt     (lft_lt),
			.left_entry  (lft_ent),
			.right_entry (rgt_ent),
			.hit_in      (hit_c[g]),
			.lt          (lt_c[g]),
			.hit_out     (hit_c[g+1]),
			.entry       (ent_c[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.ins) begin
			fill_q <= fill_q + 1'b1;
		end else if (ctl.rem || ctl.pop) begin
			fill_q <= fill_q - 1'b1;
		end
	end

	assign stat.head  = ent_c[0];
	assign stat.full  = (fill_q == CNT_BITS'(LIST_DEPTH));
	assign stat.empty = (fill_q == '0);
	assign stat.found = found;
	assign stat.fill  = fill_q;

endmodule

>>> bench/dual_sorted_list_engine_core_tb.sv
// Self-checking testbench for dual_sorted_list_engine_core: directed steps, then random requests.
// Depends on dsl_pkg and the engine RTL; every result is checked against a list predictor or a typed-in result.
module dual_sorted_list_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsl_pkg::*;

	// One result as it leaves the block; compared field by field.
	typedef struct packed {
		logic [1:0]                status;
		logic [FIELD_KEY_BITS-1:0] moved;
		logic [FIELD_CNT_BITS-1:0] active_cnt;
		logic [FIELD_CNT_BITS-1:0] pending_cnt;
	} outcome_t;

	// One row of the directed part. A row may be issued several times in a row, and
	// carries a typed-in result only where that result is obvious by inspection.
	typedef struct packed {
		logic [1:0] op;
		key_t       key;
		logic [4:0] repeats;
		logic       has_want;
		outcome_t   want;
	} step_t;

	localparam int STEP_COUNT = 24;
	localparam int RANDOM_PER_PHASE = 435;
	localparam int SHOWN_FAILURES = 10;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] operation;
	logic [15:0] item_key;
	logic       done;
	logic [1:0] status;
	logic [15:0] moved_key;
	logic [4:0] active_count;
	logic [4:0] pending_count;

	// Predictor state: both lists held head first, i.e. largest id at index 0.
	key_t active_ids[$];
	key_t pending_ids[$];

	// Results predicted at request acceptance and not yet seen on the result ports.
	outcome_t awaited_outcomes[$];

	int failures = 0;
	int sender_idle_pct = 0;
	step_t directed_steps[STEP_COUNT];

	dual_sorted_list_engine_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.item_key     (item_key),
		.done         (done),
		.status       (status),
		.moved_key    (moved_key),
		.active_count (active_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop. The slowest legal run is well under a hundred microseconds, so this
	// only fires if the handshake hangs.
	initial begin
		#2_000_000;
		$display("dual_sorted_list_engine_core_tb: FAIL");
		$finish;
	end

	function automatic outcome_t outcome(logic [1:0] st, key_t mv, int a_cnt, int p_cnt);
		outcome_t o;
		o.status = st;
		o.moved = mv;
		o.active_cnt = a_cnt[FIELD_CNT_BITS-1:0];
		o.pending_cnt = p_cnt[FIELD_CNT_BITS-1:0];
		return o;
	endfunction

	// Place of a new id in a descending list: before the first entry strictly smaller,
	// so that equal ids stay in arrival order.
	function automatic int slot_for(key_t ids[$], key_t key);
		for (int i = 0; i < ids.size(); i++) begin
			if (ids[i] < key) begin
				return i;
			end
		end
		return ids.size();
	endfunction

	// Applies one accepted request to the predicted lists and returns its result.
	function automatic outcome_t predict_list_op(logic [1:0] op, key_t key);
		logic [1:0] st;
		key_t       mv;
		key_t       head;
		int         hit;
		st = ST_OK;
		mv = '0;
		hit = -1;
		case (op)
			OP_INS_ACTIVE: begin
				if (active_ids.size() >= LIST_DEPTH)
					st = ST_FULL;
				else
					active_ids.insert(slot_for(active_ids, key), key);
			end
			OP_INS_PENDING: begin
				if (pending_ids.size() >= LIST_DEPTH)
					st = ST_FULL;
				else
					pending_ids.insert(slot_for(pending_ids, key), key);
			end
			OP_REMOVE: begin
				// Only the head-most match goes.
				for (int i = 0; i < active_ids.size() && hit < 0; i++) begin
					if (active_ids[i] == key)
						hit = i;
				end
				if (hit < 0)
					st = ST_NOT_FOUND;
				else
					active_ids.delete(hit);
			end
			default: begin
				// An empty pending list wins over a full active list.
				if (pending_ids.size() == 0) begin
					st = ST_EMPTY;
				end else if (active_ids.size() >= LIST_DEPTH) begin
					st = ST_FULL;
				end else begin
					head = pending_ids.pop_front();
					active_ids.insert(slot_for(active_ids, head), head);
					mv = head;
				end
			end
		endcase
		return outcome(st, mv, active_ids.size(), pending_ids.size());
	endfunction

	// Random id: often fully random, sometimes an extreme, sometimes one already held
	// so that duplicates and exact matches keep coming up.
	function automatic key_t random_key();
		key_t pool[4];
		pool[0] = '0;
		pool[1] = '1;
		pool[2] = 16'h8000;
		pool[3] = 16'h7FFF;
		case ($urandom_range(3))
			0, 1: return key_t'($urandom);
			2: begin
				if ($urandom_range(1))
					return pool[$urandom_range(3)];
				return key_t'($urandom_range(3));
			end
			default: begin
				if (active_ids.size() > 0 && $urandom_range(1))
					return active_ids[$urandom_range(active_ids.size() - 1)];
				if (pending_ids.size() > 0)
					return pending_ids[$urandom_range(pending_ids.size() - 1)];
				return key_t'($urandom);
			end
		endcase
	endfunction

	// Issues one request, idling first at the current sender rate. Start is left high
	// afterwards so back-to-back requests never toggle it within one time step.
	task automatic send_request(input logic [1:0] op, input key_t key, input logic has_want,
			input outcome_t want);
		outcome_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		item_key <= key;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// Accepted at this edge: the predictor runs now, so the next random choice sees
		// the lists as they stand after this request.
		predicted = predict_list_op(op, key);
		awaited_outcomes.push_back(has_want ? want : predicted);
	endtask

	function automatic void report_failure(string what, outcome_t wanted, outcome_t seen);
		failures++;
		if (failures <= SHOWN_FAILURES) begin
			$write("%0t ns: %s: expected status %0d moved %h active %0d pending %0d",
				$realtime, what, wanted.status, wanted.moved, wanted.active_cnt,
				wanted.pending_cnt);
			$display(", got status %0d moved %h active %0d pending %0d",
				seen.status, seen.moved, seen.active_cnt, seen.pending_cnt);
		end
	endfunction

	// Result checker. Results cannot be held off, so every strobed cycle is consumed.
	// Outputs are read right after the edge, before the block's own updates land.
	always @(posedge clk) begin
		outcome_t seen;
		outcome_t wanted;
		if (arst_n && done) begin
			seen = outcome(status, moved_key, active_count, pending_count);
			if (awaited_outcomes.size() == 0) begin
				report_failure("result with no request outstanding", '0, seen);
			end else begin
				wanted = awaited_outcomes.pop_front();
				if (seen.status !== wanted.status || seen.moved !== wanted.moved ||
						seen.active_cnt !== wanted.active_cnt ||
						seen.pending_cnt !== wanted.pending_cnt)
					report_failure("result mismatch", wanted, seen);
			end
		end
	end

	// Stimulus. The directed rows walk both lists through empty and full, hit every
	// status code, promote into a full active list, and show that promote ignores the
	// key. The random part then alternates filling and draining stretches so the lists
	// keep crossing both bounds, over four phases with three sender idle rates.
	initial begin
		logic [1:0] op;
		key_t       key;
		int         pick;
		logic       filling;
		int         stretch;
		int         drain_wait;

		start <= 1'b0;
		operation <= OP_INS_ACTIVE;
		item_key <= '0;
		arst_n <= 1'b0;

		directed_steps[0]  = '{OP_PROMOTE,     16'h0000, 5'd1,  1'b1, outcome(ST_EMPTY, 0, 0, 0)};
		directed_steps[1]  = '{OP_REMOVE,      16'h1234, 5'd1,  1'b1, outcome(ST_NOT_FOUND, 0, 0, 0)};
		directed_steps[2]  = '{OP_INS_ACTIVE,  16'h0000, 5'd1,  1'b1, outcome(ST_OK, 0, 1, 0)};
		directed_steps[3]  = '{OP_INS_ACTIVE,  16'hFFFF, 5'd1,  1'b1, outcome(ST_OK, 0, 2, 0)};
		directed_steps[4]  = '{OP_INS_ACTIVE,  16'h8000, 5'd1,  1'b0, '0};
		directed_steps[5]  = '{OP_INS_ACTIVE,  16'h8000, 5'd1,  1'b0, '0};
		directed_steps[6]  = '{OP_REMOVE,      16'h8000, 5'd1,  1'b0, '0};
		directed_steps[7]  = '{OP_REMOVE,      16'hFFFF, 5'd1,  1'b0, '0};
		directed_steps[8]  = '{OP_INS_PENDING, 16'hFFFF, 5'd1,  1'b0, '0};
		directed_steps[9]  = '{OP_INS_PENDING, 16'h0000, 5'd1,  1'b0, '0};
		directed_steps[10] = '{OP_PROMOTE,     16'h0000, 5'd1,  1'b1, outcome(ST_OK, 16'hFFFF, 3, 1)};
		directed_steps[11] = '{OP_PROMOTE,     16'h5A5A, 5'd1,  1'b0, '0};
		directed_steps[12] = '{OP_PROMOTE,     16'hFFFF, 5'd1,  1'b1, outcome(ST_EMPTY, 0, 4, 0)};
		directed_steps[13] = '{OP_INS_ACTIVE,  16'h5555, 5'd12, 1'b0, '0};
		directed_steps[14] = '{OP_INS_ACTIVE,  16'h0001, 5'd1,  1'b1, outcome(ST_FULL, 0, 16, 0)};
		directed_steps[15] = '{OP_INS_PENDING, 16'hAAAA, 5'd1,  1'b0, '0};
		directed_steps[16] = '{OP_PROMOTE,     16'hFFFF, 5'd1,  1'b1, outcome(ST_FULL, 0, 16, 1)};
		directed_steps[17] = '{OP_REMOVE,      16'h5555, 5'd1,  1'b0, '0};
		directed_steps[18] = '{OP_PROMOTE,     16'h0000, 5'd1,  1'b1, outcome(ST_OK, 16'hAAAA, 16, 0)};
		directed_steps[19] = '{OP_INS_PENDING, 16'h7FFF, 5'd16, 1'b0, '0};
		directed_steps[20] = '{OP_INS_PENDING, 16'h0001, 5'd1,  1'b1, outcome(ST_FULL, 0, 16, 16)};
		directed_steps[21] = '{OP_REMOVE,      16'h1234, 5'd1,  1'b1, outcome(ST_NOT_FOUND, 0, 16, 16)};
		directed_steps[22] = '{OP_REMOVE,      16'h0000, 5'd3,  1'b0, '0};
		directed_steps[23] = '{OP_PROMOTE,     16'h0000, 5'd2,  1'b0, '0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < STEP_COUNT; i++) begin
			for (int r = 0; r < directed_steps[i].repeats; r++)
				send_request(directed_steps[i].op, directed_steps[i].key,
					directed_steps[i].has_want, directed_steps[i].want);
		end

		// Phases: back to back, heavy sender idling, back to back again (the receiver
		// cannot stall, so its phase runs at full rate), then moderate idling.
		filling = 1'b0;
		stretch = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: sender_idle_pct = 82;
				3: sender_idle_pct = 37;
				default: sender_idle_pct = 0;
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (stretch == 0) begin
					filling = ~filling;
					stretch = $urandom_range(20, 60);
				end
				stretch--;
				pick = $urandom_range(99);
				if (filling)
					op = (pick < 35) ? OP_INS_ACTIVE : (pick < 70) ? OP_INS_PENDING :
						(pick < 85) ? OP_PROMOTE : OP_REMOVE;
				else
					op = (pick < 10) ? OP_INS_ACTIVE : (pick < 20) ? OP_INS_PENDING :
						(pick < 55) ? OP_PROMOTE : OP_REMOVE;
				// Most removals name an id that is present, so deletions really happen.
				if (op == OP_REMOVE && active_ids.size() > 0 && $urandom_range(99) < 70)
					key = active_ids[$urandom_range(active_ids.size() - 1)];
				else
					key = random_key();
				send_request(op, key, 1'b0, '0);
			end
		end

		start <= 1'b0;
		drain_wait = 0;
		while (awaited_outcomes.size() > 0 && drain_wait < 1000) begin
			@(posedge clk);
			drain_wait++;
		end
		// Keep watching to catch any stray strobe after the last result.
		repeat (4) @(posedge clk);
		while (awaited_outcomes.size() > 0)
			report_failure("result never arrived", awaited_outcomes.pop_front(), '0);

		if (failures == 0)
			$display("dual_sorted_list_engine_core_tb: PASS");
		else
			$display("dual_sorted_list_engine_core_tb: FAIL");
		$finish;
	end

endmodule
